// ===== src/plasu_pkg.sv =====
// Package for the parallel lane add/subtract unit: operation codes, lane widths
// and the structs passed between the lane, merge and top modules. No dependencies.
package plasu_pkg;

   localparam int WORD_BITS  = 32;
   localparam int BYTE_LANES = 4;
   localparam int HALF_LANES = 2;
   localparam int HALF_BITS  = 16;
   localparam int OP_BITS    = 4;

   typedef enum logic [OP_BITS-1:0] {
      OP_SADD8   = 4'd0,
      OP_UADD8   = 4'd1,
      OP_SADD16  = 4'd2,
      OP_UADD16  = 4'd3,
      OP_SSUB16  = 4'd4,
      OP_USUB16  = 4'd5,
      OP_QADD16  = 4'd6,
      OP_UQADD16 = 4'd7,
      OP_QSUB16  = 4'd8,
      OP_UQSUB16 = 4'd9,
      OP_SHADD16 = 4'd10,
      OP_UHADD16 = 4'd11,
      OP_SHSUB16 = 4'd12,
      OP_UHSUB16 = 4'd13
   } op_type;

   localparam logic [HALF_BITS-1:0] SAT_SMAX = 16'h7FFF;
   localparam logic [HALF_BITS-1:0] SAT_SMIN = 16'h8000;
   localparam logic [HALF_BITS-1:0] SAT_UMAX = 16'hFFFF;
   localparam logic [HALF_BITS-1:0] SAT_UMIN = 16'h0000;

   typedef struct packed {
      logic [7:0] res;
      logic       ge;
   } byte_out_type;

   typedef struct packed {
      logic [HALF_BITS-1:0] res;
      logic                 ge;
   } half_out_type;

   typedef struct packed {
      logic                  ge_valid;
      logic [BYTE_LANES-1:0] ge_flags;
      logic [WORD_BITS-1:0]  lane_result;
   } result_type;

   // Signed ops sit at even codes, subtracts at 4,5,8,9,12,13.
   function automatic logic op_is_signed(op_type code);
      return !code[0];
   endfunction

   function automatic logic op_is_sub(op_type code);
      logic s;
      case (code)
         OP_SSUB16, OP_USUB16, OP_QSUB16, OP_UQSUB16, OP_SHSUB16, OP_UHSUB16: s = 1'b1;
         default: s = 1'b0;
      endcase
      return s;
   endfunction

endpackage

// ===== src/plasu_byte_lane.sv =====
// One byte lane: modular 8-bit add with signed or carry GE flag.
// Depends on plasu_pkg.
module plasu_byte_lane (
   input  plasu_pkg::op_type       code,
   input  logic [7:0]              a,
   input  logic [7:0]              b,
   output plasu_pkg::byte_out_type lane_out
);

   logic [8:0] usum;
   logic [9:0] ssum;

   assign usum = {1'b0, a} + {1'b0, b};
   assign ssum = {{2{a[7]}}, a} + {{2{b[7]}}, b};

   always_comb begin
      lane_out.res = usum[7:0];
      lane_out.ge  = (code == plasu_pkg::OP_SADD8) ? !ssum[9] : usum[8];
   end

endmodule

// ===== src/plasu_half_lane.sv =====
// One halfword lane: modular, saturating and halving add/subtract on 16 bits.
// Depends on plasu_pkg.
module plasu_half_lane (
   input  plasu_pkg::op_type                   code,
   input  logic [plasu_pkg::HALF_BITS-1:0]     a,
   input  logic [plasu_pkg::HALF_BITS-1:0]     b,
   output plasu_pkg::half_out_type             lane_out
);

   localparam int W = plasu_pkg::HALF_BITS;

   logic [W+1:0] a_ext;
   logic [W+1:0] b_ext;
   logic [W+1:0] r;
   logic         s_ovf;

   always_comb begin
      a_ext = plasu_pkg::op_is_signed(code) ? {{2{a[W-1]}}, a} : {2'b00, a};
      b_ext = plasu_pkg::op_is_signed(code) ? {{2{b[W-1]}}, b} : {2'b00, b};
      r     = plasu_pkg::op_is_sub(code) ? (a_ext - b_ext) : (a_ext + b_ext);
      // signed exact result fits 17 bits; signed overflow when bit 16 differs from bit 15
      s_ovf = r[W] != r[W-1];
   end

   always_comb begin
      lane_out.res = '0;
      lane_out.ge  = 1'b0;
      case (code)
         plasu_pkg::OP_SADD16, plasu_pkg::OP_SSUB16, plasu_pkg::OP_USUB16: begin
            lane_out.res = r[W-1:0];
            lane_out.ge  = !r[W+1];
         end
         plasu_pkg::OP_UADD16: begin
            lane_out.res = r[W-1:0];
            lane_out.ge  = r[W];
         end
         plasu_pkg::OP_QADD16, plasu_pkg::OP_QSUB16: begin
            if (s_ovf) begin
               lane_out.res = r[W+1] ? plasu_pkg::SAT_SMIN : plasu_pkg::SAT_SMAX;
            end else begin
               lane_out.res = r[W-1:0];
            end
         end
         plasu_pkg::OP_UQADD16: begin
            lane_out.res = r[W] ? plasu_pkg::SAT_UMAX : r[W-1:0];
         end
         plasu_pkg::OP_UQSUB16: begin
            lane_out.res = r[W+1] ? plasu_pkg::SAT_UMIN : r[W-1:0];
         end
         plasu_pkg::OP_SHADD16, plasu_pkg::OP_UHADD16,
         plasu_pkg::OP_SHSUB16, plasu_pkg::OP_UHSUB16: begin
            lane_out.res = r[W:1];
         end
         default: begin
            lane_out.res = '0;
            lane_out.ge  = 1'b0;
         end
      endcase
   end

endmodule

// ===== src/plasu_merge.sv =====
// Merge stage: picks byte or halfword lane results and builds the GE flags.
// Depends on plasu_pkg.
module plasu_merge (
   input  plasu_pkg::op_type       code,
   input  plasu_pkg::byte_out_type byte_out [plasu_pkg::BYTE_LANES],
   input  plasu_pkg::half_out_type half_out [plasu_pkg::HALF_LANES],
   output plasu_pkg::result_type   result
);

   always_comb begin
      result = '0;
      case (code)
         plasu_pkg::OP_SADD8, plasu_pkg::OP_UADD8: begin
            for (int i = 0; i < plasu_pkg::BYTE_LANES; i++) begin
               result.lane_result[8*i +: 8] = byte_out[i].res;
               result.ge_flags[i]           = byte_out[i].ge;
            end
            result.ge_valid = 1'b1;
         end
         plasu_pkg::OP_SADD16, plasu_pkg::OP_UADD16,
         plasu_pkg::OP_SSUB16, plasu_pkg::OP_USUB16: begin
            for (int i = 0; i < plasu_pkg::HALF_LANES; i++) begin
               result.lane_result[plasu_pkg::HALF_BITS*i +: plasu_pkg::HALF_BITS] =
                  half_out[i].res;
               result.ge_flags[2*i +: 2] = {2{half_out[i].ge}};
            end
            result.ge_valid = 1'b1;
         end
         plasu_pkg::OP_QADD16, plasu_pkg::OP_UQADD16, plasu_pkg::OP_QSUB16,
         plasu_pkg::OP_UQSUB16, plasu_pkg::OP_SHADD16, plasu_pkg::OP_UHADD16,
         plasu_pkg::OP_SHSUB16, plasu_pkg::OP_UHSUB16: begin
            // no GE update: flags stay zero
            for (int i = 0; i < plasu_pkg::HALF_LANES; i++) begin
               result.lane_result[plasu_pkg::HALF_BITS*i +: plasu_pkg::HALF_BITS] =
                  half_out[i].res;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

// ===== src/parallel_lane_add_sub_unit.sv =====
// Parallel lane add/subtract unit: four byte lanes and two halfword lanes feed
// a merge stage whose result is held in one output register, loaded in the cycle
// after a word is taken. Throughput: 1 word per cycle while rsp_tready is high,
// set by the single output register, which refills in the cycle it drains.
// Reset: synchronous, active high; clears the output valid flag only.
// Depends on plasu_pkg, plasu_byte_lane, plasu_half_lane, plasu_merge.
module parallel_lane_add_sub_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] left_operand, [63:32] right_operand
   input  logic [7:0]  req_tuser,   // [3:0] req_type, [7:4] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] lane_result
   output logic [7:0]  rsp_tuser    // [3:0] ge_flags, [4] ge_valid, [7:5] zero
);

   localparam int W  = plasu_pkg::WORD_BITS;
   localparam int HB = plasu_pkg::HALF_BITS;

   plasu_pkg::op_type       code;
   logic [W-1:0]            left_op;
   logic [W-1:0]            right_op;
   plasu_pkg::byte_out_type byte_out [plasu_pkg::BYTE_LANES];
   plasu_pkg::half_out_type half_out [plasu_pkg::HALF_LANES];
   plasu_pkg::result_type   result;

   plasu_pkg::result_type   rsp_data_ff, rsp_data_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    req_fire;

   assign code     = plasu_pkg::op_type'(req_tuser[plasu_pkg::OP_BITS-1:0]);
   assign left_op  = req_tdata[W-1:0];
   assign right_op = req_tdata[2*W-1:W];

   for (genvar i = 0; i < plasu_pkg::BYTE_LANES; i++) begin : g_byte
      plasu_byte_lane u_byte (
         .code     (code),
         .a        (left_op[8*i +: 8]),
         .b        (right_op[8*i +: 8]),
         .lane_out (byte_out[i])
      );
   end

   for (genvar i = 0; i < plasu_pkg::HALF_LANES; i++) begin : g_half
      plasu_half_lane u_half (
         .code     (code),
         .a        (left_op[HB*i +: HB]),
         .b        (right_op[HB*i +: HB]),
         .lane_out (half_out[i])
      );
   end

   plasu_merge u_merge (
      .code     (code),
      .byte_out (byte_out),
      .half_out (half_out),
      .result   (result)
   );

   // take a new word whenever the output register is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff.lane_result;
   assign rsp_tuser  = {3'b000, rsp_data_ff.ge_valid, rsp_data_ff.ge_flags};

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("accepted word did not produce a result word");

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output register");

   a_ge_valid_code: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tuser[4] == ($past(req_tuser[3:0]) <= 4'd5))
      else $error("ge_valid does not match operation code");

   a_ge_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[4]) |-> rsp_tuser[3:0] == 4'd0)
      else $error("GE flags set on an operation without GE update");

endmodule

// ===== tb/tb_parallel_lane_add_sub_unit.sv =====
// Self-checking testbench for parallel_lane_add_sub_unit: directed vectors, then random
// words under three sender/receiver idle mixes, each result compared against a stored or predicted word.
// Depends on plasu_pkg and the parallel_lane_add_sub_unit RTL.
module tb_parallel_lane_add_sub_unit;

   localparam logic [3:0] UNUSED_CODE_LO = 4'd14;
   localparam logic [3:0] UNUSED_CODE_HI = 4'd15;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int WORDS_PER_MIX  = 350;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int NUM_VECTORS    = 23;

   typedef struct {
      logic [3:0]            code;
      logic [31:0]           left;
      logic [31:0]           right;
      bit                    typed;
      plasu_pkg::result_type want;
   } lane_vector_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [31:0] left_operand, [63:32] right_operand
   logic [7:0]  req_tuser = '0;   // [3:0] req_type, [7:4] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] lane_result
   logic [7:0]  rsp_tuser;        // [3:0] ge_flags, [4] ge_valid, [7:5] zero

   plasu_pkg::result_type pending_lane_words[$];
   lane_vector_type       lane_vectors[NUM_VECTORS];
   int           fault_count = 0;
   int           cycle_count = 0;
   int           sender_gap_pct = 0;
   int           receiver_gap_pct = 0;
   bit           hold_off_req = 1'b0;
   bit           hold_off_done = 1'b0;
   int           hold_off_left = 0;

   parallel_lane_add_sub_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int saturate(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic plasu_pkg::result_type predict_lane_word(logic [3:0] code,
                                                               logic [31:0] a,
                                                               logic [31:0] b);
      plasu_pkg::result_type r;
      int         i;
      int         lhs_s, rhs_s, lhs_u, rhs_u, full;
      bit         ge;
      r = '0;
      if (code == plasu_pkg::OP_SADD8 || code == plasu_pkg::OP_UADD8) begin
         for (i = 0; i < 4; i++) begin
            lhs_u = int'(a[8*i +: 8]);
            rhs_u = int'(b[8*i +: 8]);
            lhs_s = int'($signed(a[8*i +: 8]));
            rhs_s = int'($signed(b[8*i +: 8]));
            full  = lhs_u + rhs_u;
            r.lane_result[8*i +: 8] = full[7:0];
            r.ge_flags[i] = (code == plasu_pkg::OP_SADD8) ? (lhs_s + rhs_s >= 0)
                                                          : (full >= 256);
         end
         r.ge_valid = 1'b1;
      end else if (code <= plasu_pkg::OP_UHSUB16) begin
         for (i = 0; i < 2; i++) begin
            lhs_u = int'(a[16*i +: 16]);
            rhs_u = int'(b[16*i +: 16]);
            lhs_s = int'($signed(a[16*i +: 16]));
            rhs_s = int'($signed(b[16*i +: 16]));
            ge    = 1'b0;
            case (code)
               plasu_pkg::OP_SADD16: begin full = lhs_s + rhs_s; ge = full >= 0; end
               plasu_pkg::OP_UADD16: begin full = lhs_u + rhs_u; ge = full >= 32'h10000; end
               plasu_pkg::OP_SSUB16: begin full = lhs_s - rhs_s; ge = full >= 0; end
               plasu_pkg::OP_USUB16: begin full = lhs_u - rhs_u; ge = full >= 0; end
               plasu_pkg::OP_QADD16:  full = saturate(lhs_s + rhs_s, -32768, 32767);
               plasu_pkg::OP_UQADD16: full = saturate(lhs_u + rhs_u, 0, 65535);
               plasu_pkg::OP_QSUB16:  full = saturate(lhs_s - rhs_s, -32768, 32767);
               plasu_pkg::OP_UQSUB16: full = saturate(lhs_u - rhs_u, 0, 65535);
               // halving: take bits 16:1 of the exact sum or difference
               plasu_pkg::OP_SHADD16: full = (lhs_s + rhs_s) >>> 1;
               plasu_pkg::OP_UHADD16: full = (lhs_u + rhs_u) >>> 1;
               plasu_pkg::OP_SHSUB16: full = (lhs_s - rhs_s) >>> 1;
               default:    full = (lhs_u - rhs_u) >>> 1;
            endcase
            r.lane_result[16*i +: 16] = full[15:0];
            if (ge) r.ge_flags[2*i +: 2] = 2'b11;
         end
         r.ge_valid = (code <= plasu_pkg::OP_USUB16);
      end
      return r;
   endfunction

   // Mix plain random lanes with boundary halfwords and bytes.
   function automatic logic [31:0] pick_operand();
      logic [31:0] v;
      int          i;
      v = $urandom();
      case ($urandom_range(3))
         2: for (i = 0; i < 2; i++) begin
               case ($urandom_range(4))
                  0: v[16*i +: 16] = plasu_pkg::SAT_UMIN;
                  1: v[16*i +: 16] = 16'h0001;
                  2: v[16*i +: 16] = plasu_pkg::SAT_SMAX;
                  3: v[16*i +: 16] = plasu_pkg::SAT_SMIN;
                  default: v[16*i +: 16] = plasu_pkg::SAT_UMAX;
               endcase
            end
         3: for (i = 0; i < 4; i++) begin
               case ($urandom_range(4))
                  0: v[8*i +: 8] = 8'h00;
                  1: v[8*i +: 8] = 8'h01;
                  2: v[8*i +: 8] = 8'h7F;
                  3: v[8*i +: 8] = 8'h80;
                  default: v[8*i +: 8] = 8'hFF;
               endcase
            end
         default: ;
      endcase
      return v;
   endfunction

   // Entered at a rising edge; returns at the edge where the word is taken.
   task automatic send_lane_word(logic [3:0] code, logic [31:0] a, logic [31:0] b,
                                 bit typed, plasu_pkg::result_type want);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tuser  <= {4'b0000, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_lane_words.push_back(typed ? want : predict_lane_word(code, a, b));
   endtask

   task automatic send_random_words(int count);
      int n;
      for (n = 0; n < count; n++)
         send_lane_word(4'($urandom_range(15)), pick_operand(), pick_operand(), 1'b0, '0);
   endtask

   // Receiver: random stalls, plus one long hold-off when requested.
   always @(posedge clock) begin
      if (hold_off_req && !hold_off_done) begin
         hold_off_left = HOLD_OFF_CYCLES;
         hold_off_done = 1'b1;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_gap_pct);
      end
   end

   always @(posedge clock) begin : rsp_check
      plasu_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_lane_words.size() == 0) begin
            $error("unexpected result word: lane_result %h, tuser %h", rsp_tdata, rsp_tuser);
            fault_count++;
         end else begin
            want = pending_lane_words.pop_front();
            if (rsp_tdata !== want.lane_result) begin
               $error("lane_result: expected %h, got %h", want.lane_result, rsp_tdata);
               fault_count++;
            end
            if (rsp_tuser[3:0] !== want.ge_flags) begin
               $error("ge_flags: expected %h, got %h", want.ge_flags, rsp_tuser[3:0]);
               fault_count++;
            end
            if (rsp_tuser[4] !== want.ge_valid) begin
               $error("ge_valid: expected %b, got %b", want.ge_valid, rsp_tuser[4]);
               fault_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("parallel_lane_add_sub_unit verification failed");
         $finish;
      end
   end

   initial begin : main_flow
      int k;
      lane_vectors = '{
         '{plasu_pkg::OP_UADD8,   32'hFFFFFFFF, 32'h01010101, 1'b1, '{1'b1, 4'hF, 32'h00000000}},
         '{plasu_pkg::OP_SADD8,   32'h00000000, 32'h00000000, 1'b1, '{1'b1, 4'hF, 32'h00000000}},
         '{plasu_pkg::OP_SADD8,   32'h80808080, 32'h80808080, 1'b1, '{1'b1, 4'h0, 32'h00000000}},
         '{plasu_pkg::OP_SADD8,   32'h7F7F7F7F, 32'h7F01FF80, 1'b0, '0},
         '{plasu_pkg::OP_UADD8,   32'h12345678, 32'h9ABCDEF0, 1'b0, '0},
         '{plasu_pkg::OP_SADD16,  32'h7FFF8000, 32'h00018000, 1'b0, '0},
         '{plasu_pkg::OP_UADD16,  32'hFFFF0001, 32'h0001FFFF, 1'b1, '{1'b1, 4'hF, 32'h00000000}},
         '{plasu_pkg::OP_SSUB16,  32'h80007FFF, 32'h0001FFFF, 1'b0, '0},
         '{plasu_pkg::OP_USUB16,  32'h00000001, 32'h00010000, 1'b0, '0},
         '{plasu_pkg::OP_USUB16,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{1'b1, 4'hF, 32'h00000000}},
         '{plasu_pkg::OP_QADD16,  32'h7FFF8000, 32'h7FFF8000, 1'b1, '{1'b0, 4'h0, 32'h7FFF8000}},
         '{plasu_pkg::OP_UQADD16, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{1'b0, 4'h0, 32'hFFFFFFFF}},
         '{plasu_pkg::OP_QSUB16,  32'h80007FFF, 32'h7FFF8000, 1'b1, '{1'b0, 4'h0, 32'h80007FFF}},
         '{plasu_pkg::OP_UQSUB16, 32'h00000000, 32'hFFFFFFFF, 1'b1, '{1'b0, 4'h0, 32'h00000000}},
         '{plasu_pkg::OP_SHADD16, 32'h7FFF8000, 32'h7FFF8000, 1'b0, '0},
         '{plasu_pkg::OP_UHADD16, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, '0},
         '{plasu_pkg::OP_SHSUB16, 32'h80007FFF, 32'h7FFF8000, 1'b0, '0},
         '{plasu_pkg::OP_UHSUB16, 32'h00000000, 32'h00010001, 1'b0, '0},
         '{plasu_pkg::OP_UHSUB16, 32'hFFFF1234, 32'h0000ABCD, 1'b0, '0},
         '{UNUSED_CODE_LO,        32'h12345678, 32'hFFFFFFFF, 1'b1, '{1'b0, 4'h0, 32'h00000000}},
         '{UNUSED_CODE_HI,        32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, '{1'b0, 4'h0, 32'h00000000}},
         '{plasu_pkg::OP_QADD16,  32'h12345678, 32'h11111111, 1'b0, '0},
         '{plasu_pkg::OP_UQSUB16, 32'hFFFF8000, 32'h0001FFFF, 1'b0, '0}
      };
      sender_gap_pct   <= 11;
      receiver_gap_pct <= 52;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < NUM_VECTORS; k++)
         send_lane_word(lane_vectors[k].code, lane_vectors[k].left, lane_vectors[k].right,
                        lane_vectors[k].typed, lane_vectors[k].want);
      send_random_words(WORDS_PER_MIX);

      sender_gap_pct   <= 52;
      receiver_gap_pct <= 11;
      send_random_words(WORDS_PER_MIX);

      // no idling; stall the receiver for a while so the input backs up
      sender_gap_pct   <= 0;
      receiver_gap_pct <= 0;
      hold_off_req     <= 1'b1;
      send_random_words(WORDS_PER_MIX);

      req_tvalid <= 1'b0;
      while (pending_lane_words.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (fault_count == 0) begin
         $display("parallel_lane_add_sub_unit verification clean");
      end else begin
         $display("parallel_lane_add_sub_unit verification failed");
      end
      $finish;
   end

endmodule
